// File: hw/rtl/i2cmrt_pkg.sv
// ----------------------------------------------------------------------------
// i2cmrt_pkg
// types and constants shared by the i2c register transfer sequencer and its
// stream wrapper
// ----------------------------------------------------------------------------
package i2cmrt_pkg;

  // pin phase of the bus sequencer
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_SDA1 = 5'd1,
    PH_ST_SCL1 = 5'd2,
    PH_ST_SDA0 = 5'd3,
    PH_ST_SCL0 = 5'd4,
    PH_TX_SDA  = 5'd5,
    PH_TX_SCLH = 5'd6,
    PH_TX_SCLL = 5'd7,
    PH_AK_SDA1 = 5'd8,
    PH_AK_SCLH = 5'd9,
    PH_AK_GET  = 5'd10,
    PH_AK_SCLL = 5'd11,
    PH_RX_SDA1 = 5'd12,
    PH_RX_SCLH = 5'd13,
    PH_RX_GET  = 5'd14,
    PH_RX_SCLL = 5'd15,
    PH_KA_SDA  = 5'd16,
    PH_KA_SCLH = 5'd17,
    PH_KA_SCLL = 5'd18,
    PH_SP_SDA0 = 5'd19,
    PH_SP_SCL1 = 5'd20,
    PH_SP_SDA1 = 5'd21
  } phase_t;

  // which byte of the transaction is on the bus
  typedef enum logic [2:0] {
    SG_DEV  = 3'd0,
    SG_MEM  = 3'd1,
    SG_RDEV = 3'd2,
    SG_DATA = 3'd3,
    SG_READ = 3'd4
  } stage_t;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PING  = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_BEGIN = 1'b1;

  localparam int TICKS_W   = 16;
  localparam int COUNT_W   = 9;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 16;

  // read address flag set on the repeated start
  localparam logic [7:0] RD_FLAG = 8'h01;

  typedef struct packed {
    logic               kind;
    logic [1:0]         op;
    logic [7:0]         target_addr;
    logic [7:0]         reg_addr;
    logic [COUNT_W-1:0] byte_count;
    logic [7:0]         write_data;
    logic               sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       want_data;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       nack_seen;
    logic       done_res;
    logic       ping_ack;
  } res_t;

endpackage

// File: hw/rtl/i2cmrt_seq.sv
// ----------------------------------------------------------------------------
// i2cmrt_seq
// bus phase sequencer: state registers plus the one-item step logic
// ----------------------------------------------------------------------------
module i2cmrt_seq #(
  parameter int MAX_BYTES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  i2cmrt_pkg::item_t            item,
  input  logic [i2cmrt_pkg::TICKS_W-1:0] phase_ticks,
  output i2cmrt_pkg::res_t             res
);
  import i2cmrt_pkg::*;

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  phase_t             phase_state, phase_state_next;
  stage_t             stage, stage_next;
  logic [2:0]         bit_index, bit_index_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic [CNT_W-1:0]   bytes_left, bytes_left_next;
  logic [TICKS_W-1:0] phase_timer, phase_timer_next;
  logic [1:0]         current_op, current_op_next;
  logic [7:0]         saved_device, saved_device_next;
  logic [7:0]         saved_register, saved_register_next;
  logic               last_ack, last_ack_next;
  logic               scl_reg, scl_reg_next;
  logic               sda_reg, sda_reg_next;

  logic [CMP_W-1:0]   count_ext;
  logic [CMP_W-1:0]   count_sat;
  logic [TICKS_W:0]   timer_inc;
  logic [TICKS_W:0]   len_ext;
  logic               phase_end;
  logic               want, rvalid, done;
  logic [7:0]         rbyte;

  // clamp the requested count to the buffer limit
  assign count_ext = CMP_W'(item.byte_count);
  assign count_sat = (count_ext > CMP_W'(MAX_BYTES)) ? CMP_W'(MAX_BYTES) : count_ext;

  assign timer_inc = {1'b0, phase_timer} + 1'b1;
  assign len_ext   = (phase_ticks == '0) ? (TICKS_W+1)'(1) : {1'b0, phase_ticks};
  assign phase_end = (timer_inc >= len_ext);

  always_comb begin
    phase_state_next    = phase_state;
    stage_next          = stage;
    bit_index_next      = bit_index;
    shift_byte_next     = shift_byte;
    bytes_left_next     = bytes_left;
    phase_timer_next    = phase_timer;
    current_op_next     = current_op;
    saved_device_next   = saved_device;
    saved_register_next = saved_register;
    last_ack_next       = last_ack;
    scl_reg_next        = scl_reg;
    sda_reg_next        = sda_reg;
    want   = 1'b0;
    rvalid = 1'b0;
    done   = 1'b0;
    rbyte  = 8'd0;

    if (en) begin
      if (item.kind == KIND_BEGIN) begin
        if (phase_state == PH_IDLE && item.op != OP_RSVD) begin
          current_op_next     = item.op;
          saved_device_next   = item.target_addr;
          saved_register_next = item.reg_addr;
          bytes_left_next     = CNT_W'(count_sat);
          if (item.op == OP_READ && count_sat == '0) begin
            bytes_left_next = CNT_W'(1);
          end
          stage_next       = SG_DEV;
          bit_index_next   = 3'd0;
          shift_byte_next  = 8'd0;
          phase_timer_next = '0;
          phase_state_next = PH_ST_SDA1;
        end
      end else if (phase_state != PH_IDLE) begin
        // pin action on the first tick of the phase
        if (phase_timer == '0) begin
          if (phase_state == PH_TX_SDA && stage == SG_DATA && bit_index == 3'd0) begin
            shift_byte_next = item.write_data;
          end
          case (phase_state)
            PH_ST_SDA1, PH_AK_SDA1, PH_RX_SDA1, PH_SP_SDA1: sda_reg_next = 1'b1;
            PH_ST_SDA0, PH_SP_SDA0: sda_reg_next = 1'b0;
            PH_ST_SCL1, PH_TX_SCLH, PH_AK_SCLH, PH_RX_SCLH,
            PH_KA_SCLH, PH_SP_SCL1: scl_reg_next = 1'b1;
            PH_ST_SCL0, PH_AK_SCLL, PH_RX_SCLL, PH_KA_SCLL: scl_reg_next = 1'b0;
            PH_TX_SCLL: begin
              scl_reg_next    = 1'b0;
              shift_byte_next = {shift_byte_next[6:0], 1'b0};
            end
            PH_TX_SDA: sda_reg_next = shift_byte_next[7];
            PH_KA_SDA: sda_reg_next = (bytes_left <= CNT_W'(1));
            default: ;
          endcase
        end

        if (phase_end) begin
          if (phase_state == PH_AK_GET) begin
            last_ack_next = item.sda_in;
          end else if (phase_state == PH_RX_GET) begin
            shift_byte_next = {shift_byte_next[6:0], item.sda_in};
          end
          phase_timer_next = '0;

          case (phase_state)
            PH_ST_SDA1: phase_state_next = PH_ST_SCL1;
            PH_ST_SCL1: phase_state_next = PH_ST_SDA0;
            PH_ST_SDA0: phase_state_next = PH_ST_SCL0;
            PH_ST_SCL0: begin
              shift_byte_next  = (stage == SG_RDEV) ? (saved_device | RD_FLAG)
                                                    : saved_device;
              bit_index_next   = 3'd0;
              phase_state_next = PH_TX_SDA;
            end
            PH_TX_SDA:  phase_state_next = PH_TX_SCLH;
            PH_TX_SCLH: phase_state_next = PH_TX_SCLL;
            PH_TX_SCLL: begin
              if (bit_index == 3'd7) begin
                bit_index_next   = 3'd0;
                phase_state_next = PH_AK_SDA1;
              end else begin
                bit_index_next   = bit_index + 3'd1;
                phase_state_next = PH_TX_SDA;
              end
            end
            PH_AK_SDA1: phase_state_next = PH_AK_SCLH;
            PH_AK_SCLH: phase_state_next = PH_AK_GET;
            PH_AK_GET:  phase_state_next = PH_AK_SCLL;
            PH_AK_SCLL: begin
              if (stage == SG_DEV) begin
                if (current_op == OP_PING) begin
                  phase_state_next = PH_SP_SDA0;
                end else begin
                  stage_next       = SG_MEM;
                  shift_byte_next  = saved_register;
                  bit_index_next   = 3'd0;
                  phase_state_next = PH_TX_SDA;
                end
              end else if (stage == SG_MEM) begin
                if (current_op == OP_READ) begin
                  stage_next       = SG_RDEV;
                  phase_state_next = PH_ST_SDA1;
                end else if (bytes_left != '0) begin
                  stage_next       = SG_DATA;
                  shift_byte_next  = 8'd0;
                  bit_index_next   = 3'd0;
                  phase_state_next = PH_TX_SDA;
                  want             = 1'b1;
                end else begin
                  phase_state_next = PH_SP_SDA0;
                end
              end else if (stage == SG_RDEV) begin
                stage_next       = SG_READ;
                shift_byte_next  = 8'd0;
                bit_index_next   = 3'd0;
                phase_state_next = PH_RX_SDA1;
              end else begin
                // ack slot of a data byte over: count it off
                if (bytes_left != '0) begin
                  bytes_left_next = bytes_left - CNT_W'(1);
                end
                if (bytes_left_next != '0) begin
                  shift_byte_next  = 8'd0;
                  bit_index_next   = 3'd0;
                  phase_state_next = PH_TX_SDA;
                  want             = 1'b1;
                end else begin
                  phase_state_next = PH_SP_SDA0;
                end
              end
            end
            PH_RX_SDA1: phase_state_next = PH_RX_SCLH;
            PH_RX_SCLH: phase_state_next = PH_RX_GET;
            PH_RX_GET:  phase_state_next = PH_RX_SCLL;
            PH_RX_SCLL: begin
              if (bit_index == 3'd7) begin
                bit_index_next   = 3'd0;
                rvalid           = 1'b1;
                rbyte            = shift_byte_next;
                phase_state_next = PH_KA_SDA;
              end else begin
                bit_index_next   = bit_index + 3'd1;
                phase_state_next = PH_RX_SCLH;
              end
            end
            PH_KA_SDA:  phase_state_next = PH_KA_SCLH;
            PH_KA_SCLH: phase_state_next = PH_KA_SCLL;
            PH_KA_SCLL: begin
              if (bytes_left != '0) begin
                bytes_left_next = bytes_left - CNT_W'(1);
              end
              if (bytes_left_next != '0) begin
                shift_byte_next  = 8'd0;
                bit_index_next   = 3'd0;
                phase_state_next = PH_RX_SDA1;
              end else begin
                phase_state_next = PH_SP_SDA0;
              end
            end
            PH_SP_SDA0: phase_state_next = PH_SP_SCL1;
            PH_SP_SCL1: phase_state_next = PH_SP_SDA1;
            PH_SP_SDA1: begin
              done             = 1'b1;
              phase_state_next = PH_IDLE;
            end
            default: phase_state_next = PH_IDLE;
          endcase
        end else begin
          phase_timer_next = timer_inc[TICKS_W-1:0];
        end
      end
    end
  end

  always_comb begin
    res.scl_level  = scl_reg_next;
    res.sda_level  = sda_reg_next;
    res.busy_res   = (phase_state_next != PH_IDLE);
    res.want_data  = want;
    res.read_valid = rvalid;
    res.read_byte  = rbyte;
    res.nack_seen  = last_ack_next;
    res.done_res   = done;
    res.ping_ack   = done && (current_op_next == OP_PING) && !last_ack_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_state    <= PH_IDLE;
      stage          <= SG_DEV;
      bit_index      <= 3'd0;
      shift_byte     <= 8'd0;
      bytes_left     <= '0;
      phase_timer    <= '0;
      current_op     <= OP_WRITE;
      saved_device   <= 8'd0;
      saved_register <= 8'd0;
      last_ack       <= 1'b0;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
    end else begin
      phase_state    <= phase_state_next;
      stage          <= stage_next;
      bit_index      <= bit_index_next;
      shift_byte     <= shift_byte_next;
      bytes_left     <= bytes_left_next;
      phase_timer    <= phase_timer_next;
      current_op     <= current_op_next;
      saved_device   <= saved_device_next;
      saved_register <= saved_register_next;
      last_ack       <= last_ack_next;
      scl_reg        <= scl_reg_next;
      sda_reg        <= sda_reg_next;
    end
  end

  // a received byte is only reported at the end of its eighth bit
  assert property (@(posedge clk) disable iff (rst)
    (en && res.read_valid) |-> (phase_state == PH_RX_SCLL && bit_index == 3'd7))
    else $error("read byte reported outside the last receive bit");

  // stop completion always returns the sequencer to idle
  assert property (@(posedge clk) disable iff (rst)
    (en && res.done_res) |=> (phase_state == PH_IDLE))
    else $error("sequencer not idle after stop");

  // a data request is followed by a data byte transmit phase
  assert property (@(posedge clk) disable iff (rst)
    (en && res.want_data) |=> (phase_state == PH_TX_SDA && stage == SG_DATA
                               && bit_index == 3'd0))
    else $error("data request without data byte phase");

endmodule

// File: hw/rtl/i2c_master_register_transfer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_register_transfer_unit
// i2c master for ping, register write and register read, one pin phase per
// configurable number of ticks, behind stream input and output ports
// ----------------------------------------------------------------------------
// a word accepted into the input stage is stepped through the sequencer into the result register
// throughput: one input word per cycle, sustained, as long as results are taken
// a one-word input stage and a one-word result register decouple the two sides
// reset (rst, synchronous): sequencer idle, scl and sda released high,
//   phase_ticks back to 1, both stream stages empty
module i2c_master_register_transfer_unit #(
  parameter int MAX_BYTES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration: phase_ticks
  input  logic                                cfg_we,
  input  logic [i2cmrt_pkg::TICKS_W-1:0]      cfg_wdata,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // op[1:0], target_addr[9:2], reg_addr[17:10], byte_count[26:18],
  // write_data[34:27], sda_in[35], zero[39:36]
  input  logic [i2cmrt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind[0]: 0 tick, 1 begin
  input  logic [0:0]                          s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // scl_level[0], sda_level[1], busy_res[2], want_data[3], read_valid[4],
  // read_byte[12:5], nack_seen[13], done_res[14], ping_ack[15]
  output logic [i2cmrt_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import i2cmrt_pkg::*;

  logic [TICKS_W-1:0] phase_ticks;

  // input stage
  logic  in_valid;
  item_t in_item;

  // result register
  res_t  out_res;
  res_t  step_res;

  logic  take_in;   // word accepted on the slave side
  logic  advance;   // result register can take a new word
  logic  step_en;   // held word goes through the sequencer this cycle

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step_en       = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  // phase length register, takes effect from the next tick on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= TICKS_W'(1);
    end else if (cfg_we) begin
      phase_ticks <= cfg_wdata;
    end
  end

  // input stage: refilled in the same cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take_in) begin
      in_valid <= 1'b1;
    end else if (step_en) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_item.kind        <= s_axis_tuser[0];
      in_item.op          <= s_axis_tdata[1:0];
      in_item.target_addr <= s_axis_tdata[9:2];
      in_item.reg_addr    <= s_axis_tdata[17:10];
      in_item.byte_count  <= s_axis_tdata[26:18];
      in_item.write_data  <= s_axis_tdata[34:27];
      in_item.sda_in      <= s_axis_tdata[35];
    end
  end

  // bus sequencer, one held word per step
  i2cmrt_seq #(
    .MAX_BYTES(MAX_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .en         (step_en),
    .item       (in_item),
    .phase_ticks(phase_ticks),
    .res        (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res <= step_res;
    end
  end

  // pack result fields, first field lowest
  assign m_axis_tdata = {out_res.ping_ack, out_res.done_res, out_res.nack_seen,
                         out_res.read_byte, out_res.read_valid, out_res.want_data,
                         out_res.busy_res, out_res.sda_level, out_res.scl_level};

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the i2c register transfer unit: a clocked driver
// feeds tick and begin words from a queue, a bit-level predictor of the bus
// sequencer builds the expected result word for every accepted input word,
// and a clocked monitor compares each result word field by field
// ----------------------------------------------------------------------------
module tb_top;
  import i2cmrt_pkg::*;

  localparam int BYTE_LIMIT = 256;
  localparam int RANDOM_WORDS = 200;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [TICKS_W-1:0]    cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // op, target_addr, reg_addr, byte_count, write_data, sda_in
  logic [0:0]            s_axis_tuser;   // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // scl, sda, busy, want, rvalid, rbyte, nack, done, ping

  i2c_master_register_transfer_unit #(
    .MAX_BYTES(BYTE_LIMIT)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock: 10 ns period
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predicted sequencer state, advanced once per accepted input word
  // ---------------------------------------------------------------------------
  phase_t      seq_phase;
  stage_t      seq_stage;
  logic [2:0]  bit_pos;
  logic [7:0]  shift_reg;
  logic [8:0]  bytes_rem;
  logic [15:0] phase_cnt;
  logic [1:0]  cur_op;
  logic [7:0]  dev_byte;
  logic [7:0]  reg_byte;
  logic        last_nack;
  logic        scl_q;
  logic        sda_q;
  logic [15:0] ticks_cfg;

  // pending input words, expected result words
  item_t item_q[$];
  res_t  bus_exp_q[$];

  item_t drv_item;
  int    drv_gap;
  bit    drv_calm;
  int    mon_stall;
  bit    mon_calm;
  int    hold_cnt;
  bit    held_once;
  int    n_accepted;
  int    n_results;
  int    n_errors;
  int    sda_bias;   // 0 random, 1 mostly low, 2 mostly high

  // shift a new byte out, msb first
  function automatic void load_tx_byte(logic [7:0] value);
    shift_reg = value;
    bit_pos   = 3'd0;
    seq_phase = PH_TX_SDA;
  endfunction

  // one input word through the sequencer; returns the result word it yields
  function automatic res_t predict_bus(item_t it);
    res_t       r;
    logic       want;
    logic       rvalid;
    logic       done;
    logic [7:0] rbyte;
    logic [8:0] cnt;
    int         len;
    want   = 1'b0;
    rvalid = 1'b0;
    done   = 1'b0;
    rbyte  = 8'd0;
    if (it.kind == KIND_BEGIN) begin
      // begin is ignored while busy and for the undefined op code
      if (seq_phase == PH_IDLE && it.op <= OP_PING) begin
        cnt = it.byte_count;
        if (cnt > BYTE_LIMIT) cnt = 9'(BYTE_LIMIT);
        if (it.op == OP_READ && cnt == 0) cnt = 9'd1;
        cur_op    = it.op;
        dev_byte  = it.target_addr;
        reg_byte  = it.reg_addr;
        bytes_rem = cnt;
        seq_stage = SG_DEV;
        bit_pos   = 3'd0;
        shift_reg = 8'd0;
        phase_cnt = 16'd0;
        seq_phase = PH_ST_SDA1;
      end
    end else if (seq_phase != PH_IDLE) begin
      len = (ticks_cfg == 0) ? 1 : int'(ticks_cfg);
      // pin action on the first tick of a phase
      if (phase_cnt == 0) begin
        if (seq_phase == PH_TX_SDA && seq_stage == SG_DATA && bit_pos == 0)
          shift_reg = it.write_data;
        case (seq_phase)
          PH_ST_SDA1, PH_AK_SDA1, PH_RX_SDA1, PH_SP_SDA1: sda_q = 1'b1;
          PH_ST_SDA0, PH_SP_SDA0: sda_q = 1'b0;
          PH_ST_SCL1, PH_TX_SCLH, PH_AK_SCLH, PH_RX_SCLH, PH_KA_SCLH, PH_SP_SCL1:
            scl_q = 1'b1;
          PH_ST_SCL0, PH_AK_SCLL, PH_RX_SCLL, PH_KA_SCLL: scl_q = 1'b0;
          PH_TX_SCLL: begin
            scl_q     = 1'b0;
            shift_reg = {shift_reg[6:0], 1'b0};
          end
          PH_TX_SDA: sda_q = shift_reg[7];
          PH_KA_SDA: sda_q = (bytes_rem <= 1);
          default: ;
        endcase
      end
      // last tick of the phase: sample, then move on
      if (int'(phase_cnt) + 1 >= len) begin
        if (seq_phase == PH_AK_GET)
          last_nack = it.sda_in;
        else if (seq_phase == PH_RX_GET)
          shift_reg = {shift_reg[6:0], it.sda_in};
        phase_cnt = 16'd0;
        case (seq_phase)
          PH_ST_SDA1: seq_phase = PH_ST_SCL1;
          PH_ST_SCL1: seq_phase = PH_ST_SDA0;
          PH_ST_SDA0: seq_phase = PH_ST_SCL0;
          PH_ST_SCL0: begin
            if (seq_stage == SG_RDEV) load_tx_byte(dev_byte | RD_FLAG);
            else load_tx_byte(dev_byte);
          end
          PH_TX_SDA:  seq_phase = PH_TX_SCLH;
          PH_TX_SCLH: seq_phase = PH_TX_SCLL;
          PH_TX_SCLL: begin
            if (bit_pos == 3'd7) begin
              bit_pos   = 3'd0;
              seq_phase = PH_AK_SDA1;
            end else begin
              bit_pos   = bit_pos + 3'd1;
              seq_phase = PH_TX_SDA;
            end
          end
          PH_AK_SDA1: seq_phase = PH_AK_SCLH;
          PH_AK_SCLH: seq_phase = PH_AK_GET;
          PH_AK_GET:  seq_phase = PH_AK_SCLL;
          PH_AK_SCLL: begin
            case (seq_stage)
              SG_DEV: begin
                if (cur_op == OP_PING) begin
                  seq_phase = PH_SP_SDA0;
                end else begin
                  seq_stage = SG_MEM;
                  load_tx_byte(reg_byte);
                end
              end
              SG_MEM: begin
                if (cur_op == OP_READ) begin
                  // repeated start
                  seq_stage = SG_RDEV;
                  seq_phase = PH_ST_SDA1;
                end else if (bytes_rem > 0) begin
                  seq_stage = SG_DATA;
                  load_tx_byte(8'd0);
                  want = 1'b1;
                end else begin
                  seq_phase = PH_SP_SDA0;
                end
              end
              SG_RDEV: begin
                seq_stage = SG_READ;
                shift_reg = 8'd0;
                bit_pos   = 3'd0;
                seq_phase = PH_RX_SDA1;
              end
              default: begin
                if (bytes_rem > 0) bytes_rem = bytes_rem - 9'd1;
                if (bytes_rem > 0) begin
                  load_tx_byte(8'd0);
                  want = 1'b1;
                end else begin
                  seq_phase = PH_SP_SDA0;
                end
              end
            endcase
          end
          PH_RX_SDA1: seq_phase = PH_RX_SCLH;
          PH_RX_SCLH: seq_phase = PH_RX_GET;
          PH_RX_GET:  seq_phase = PH_RX_SCLL;
          PH_RX_SCLL: begin
            if (bit_pos == 3'd7) begin
              bit_pos   = 3'd0;
              rvalid    = 1'b1;
              seq_phase = PH_KA_SDA;
            end else begin
              bit_pos   = bit_pos + 3'd1;
              seq_phase = PH_RX_SCLH;
            end
          end
          PH_KA_SDA:  seq_phase = PH_KA_SCLH;
          PH_KA_SCLH: seq_phase = PH_KA_SCLL;
          PH_KA_SCLL: begin
            if (bytes_rem > 0) bytes_rem = bytes_rem - 9'd1;
            if (bytes_rem > 0) begin
              shift_reg = 8'd0;
              bit_pos   = 3'd0;
              seq_phase = PH_RX_SDA1;
            end else begin
              seq_phase = PH_SP_SDA0;
            end
          end
          PH_SP_SDA0: seq_phase = PH_SP_SCL1;
          PH_SP_SCL1: seq_phase = PH_SP_SDA1;
          PH_SP_SDA1: begin
            done      = 1'b1;
            seq_phase = PH_IDLE;
          end
          default: seq_phase = PH_IDLE;
        endcase
        if (rvalid) rbyte = shift_reg;
      end else begin
        phase_cnt = phase_cnt + 16'd1;
      end
    end
    r.scl_level  = scl_q;
    r.sda_level  = sda_q;
    r.busy_res   = (seq_phase != PH_IDLE);
    r.want_data  = want;
    r.read_valid = rvalid;
    r.read_byte  = rbyte;
    r.nack_seen  = last_nack;
    r.done_res   = done;
    r.ping_ack   = done && cur_op == OP_PING && last_nack == 1'b0;
    return r;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(item_t it);
    return {4'b0, it.sda_in, it.write_data, it.byte_count, it.reg_addr, it.target_addr,
            it.op};
  endfunction

  function automatic res_t unpack_result(logic [OUT_DATA_W-1:0] w);
    res_t r;
    r.scl_level  = w[0];
    r.sda_level  = w[1];
    r.busy_res   = w[2];
    r.want_data  = w[3];
    r.read_valid = w[4];
    r.read_byte  = w[12:5];
    r.nack_seen  = w[13];
    r.done_res   = w[14];
    r.ping_ack   = w[15];
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // word with every field random; sda follows the current bias
  function automatic item_t rand_item(logic kind);
    item_t it;
    it.kind        = kind;
    it.op          = 2'($urandom_range(0, 3));
    it.target_addr = 8'($urandom_range(0, 255));
    it.reg_addr    = 8'($urandom_range(0, 255));
    it.byte_count  = 9'($urandom_range(0, 511));
    it.write_data  = 8'($urandom_range(0, 255));
    case (sda_bias)
      1: it.sda_in = ($urandom_range(0, 7) == 0);
      2: it.sda_in = ($urandom_range(0, 7) != 0);
      default: it.sda_in = 1'($urandom_range(0, 1));
    endcase
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
             $time, what, n_results, got, want);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: one word per handshake, random gaps between words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        bus_exp_q.push_back(predict_bus(drv_item));
        n_accepted++;
        // now and then switch to a stretch with no gaps
        if (n_accepted % 64 == 0) drv_calm = ($urandom_range(0, 9) < 3);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (drv_gap > 0 || item_q.size() == 0) begin
          if (drv_gap > 0) drv_gap--;
          s_axis_tvalid <= 1'b0;
        end else begin
          drv_item = item_q.pop_front();
          s_axis_tdata  <= pack_item(drv_item);
          s_axis_tuser  <= drv_item.kind;
          s_axis_tvalid <= 1'b1;
          drv_gap = drv_calm ? 0 : idle_len();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result word against the oldest expectation,
  // stalls at random and once holds off long enough to back up the input
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      mon_stall = 0;
      hold_cnt  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        got = unpack_result(m_axis_tdata);
        if (bus_exp_q.size() == 0) begin
          report_mismatch("unexpected result word", m_axis_tdata, 0);
        end else begin
          want = bus_exp_q.pop_front();
          if (got.scl_level !== want.scl_level)
            report_mismatch("scl_level", got.scl_level, want.scl_level);
          if (got.sda_level !== want.sda_level)
            report_mismatch("sda_level", got.sda_level, want.sda_level);
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
          if (got.want_data !== want.want_data)
            report_mismatch("want_data", got.want_data, want.want_data);
          if (got.read_valid !== want.read_valid)
            report_mismatch("read_valid", got.read_valid, want.read_valid);
          if (got.read_byte !== want.read_byte)
            report_mismatch("read_byte", got.read_byte, want.read_byte);
          if (got.nack_seen !== want.nack_seen)
            report_mismatch("nack_seen", got.nack_seen, want.nack_seen);
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
          if (got.ping_ack !== want.ping_ack)
            report_mismatch("ping_ack", got.ping_ack, want.ping_ack);
        end
        if (n_results % 64 == 0) mon_calm = ($urandom_range(0, 9) < 3);
      end
      // long hold-off once, counted here while the driver keeps offering
      if (!held_once && n_results >= 500 && s_axis_tvalid) begin
        held_once = 1'b1;
        hold_cnt  = 120;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (mon_stall > 0) begin
        mon_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        mon_stall = mon_calm ? 0 : idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: runs at the falling edge so it never races the driver
  // ---------------------------------------------------------------------------
  task automatic wait_room();
    @(negedge clk);
    while (item_q.size() >= 2) @(negedge clk);
  endtask

  // nothing queued, nothing offered, nothing outstanding
  task automatic drain();
    @(negedge clk);
    while (item_q.size() != 0 || s_axis_tvalid || bus_exp_q.size() != 0) @(negedge clk);
  endtask

  // phase_ticks write while the stream is quiet
  task automatic set_phase_ticks(logic [15:0] value);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    ticks_cfg = value;
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic start_txn(logic [1:0] op, logic [7:0] dev, logic [7:0] mem,
                           logic [8:0] cnt);
    item_t it;
    it             = rand_item(KIND_BEGIN);
    it.op          = op;
    it.target_addr = dev;
    it.reg_addr    = mem;
    it.byte_count  = cnt;
    wait_room();
    item_q.push_back(it);
  endtask

  task automatic feed_ticks(int n);
    repeat (n) begin
      wait_room();
      item_q.push_back(rand_item(KIND_TICK));
    end
  endtask

  // tick words until the transaction ends; an occasional begin word lands
  // mid-transfer and must be ignored
  task automatic feed_until_idle();
    item_t it;
    do begin
      @(negedge clk);
      if (item_q.size() < 2 && seq_phase != PH_IDLE) begin
        if ($urandom_range(0, 15) == 0) it = rand_item(KIND_BEGIN);
        else it = rand_item(KIND_TICK);
        // keep a begin that slips in after the stop short
        it.byte_count = 9'($urandom_range(0, 3));
        item_q.push_back(it);
      end
    end while (seq_phase != PH_IDLE || item_q.size() != 0 || s_axis_tvalid);
  endtask

  task automatic run_txn(logic [1:0] op, logic [7:0] dev, logic [7:0] mem,
                         logic [8:0] cnt);
    start_txn(op, dev, mem, cnt);
    feed_until_idle();
  endtask

  initial begin
    item_t it;
    int    rand_base;
    int    pick;
    logic [1:0] op;
    // every input known from time zero
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    drv_calm      = 1'b0;
    mon_calm      = 1'b0;
    held_once     = 1'b0;
    n_accepted    = 0;
    n_results     = 0;
    n_errors      = 0;
    sda_bias      = 0;
    // predictor after reset
    seq_phase = PH_IDLE;
    seq_stage = SG_DEV;
    bit_pos   = '0;
    shift_reg = '0;
    bytes_rem = '0;
    phase_cnt = '0;
    cur_op    = OP_WRITE;
    dev_byte  = '0;
    reg_byte  = '0;
    last_nack = 1'b0;
    scl_q     = 1'b1;
    sda_q     = 1'b1;
    ticks_cfg = 16'd1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // ticks while idle change nothing; begin with the undefined op is dropped
    feed_ticks(3);
    it      = rand_item(KIND_BEGIN);
    it.op   = OP_RSVD;
    wait_room();
    item_q.push_back(it);
    feed_ticks(2);
    // ping acked and ping not acked
    sda_bias = 1;
    run_txn(OP_PING, 8'h00, 8'h00, 9'd0);
    sda_bias = 2;
    run_txn(OP_PING, 8'hFF, 8'hFF, 9'd0);
    sda_bias = 0;
    // write of zero bytes goes straight to stop after the register address
    run_txn(OP_WRITE, 8'hA4, 8'hFF, 9'd0);
    run_txn(OP_WRITE, 8'h5A, 8'h00, 9'd1);
    // read of zero bytes reads one
    run_txn(OP_READ, 8'hA1, 8'h3C, 9'd0);
    run_txn(OP_READ, 8'hFE, 8'h00, 9'd2);
    // phase length zero behaves as one tick
    set_phase_ticks(16'd0);
    run_txn(OP_PING, 8'h42, 8'h00, 9'd0);
    set_phase_ticks(16'd2);
    run_txn(OP_WRITE, 8'h10, 8'h81, 9'd1);
    // longest phase: run into it, then shorten it mid-phase
    set_phase_ticks(16'hFFFF);
    start_txn(OP_PING, 8'h33, 8'h00, 9'd0);
    feed_ticks(20);
    set_phase_ticks(16'd3);
    feed_until_idle();

    // --- random part: phases of a few transactions each ---
    rand_base = n_accepted;
    while (n_accepted - rand_base < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) set_phase_ticks(16'd1);
      else if (pick < 6) set_phase_ticks(16'd2);
      else if (pick < 8) set_phase_ticks(16'd3);
      else if (pick < 9) set_phase_ticks(16'd0);
      else set_phase_ticks(16'd5);
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 9);
        op = (pick < 4) ? OP_READ : (pick < 8) ? OP_WRITE : OP_PING;
        sda_bias = $urandom_range(0, 2);
        if ($urandom_range(0, 9) < 8)
          run_txn(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  9'($urandom_range(0, 3)));
        else
          run_txn(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  9'($urandom_range(4, 12)));
        // some noise between transactions
        if ($urandom_range(0, 3) == 0) begin
          it    = rand_item(KIND_BEGIN);
          it.op = OP_RSVD;
          wait_room();
          item_q.push_back(it);
          feed_ticks($urandom_range(0, 3));
        end
        if (n_accepted - rand_base >= RANDOM_WORDS) break;
      end
    end

    // wait for the last result words, then for any stray ones
    drain();
    repeat (8) @(posedge clk);
    if (bus_exp_q.size() != 0)
      report_mismatch("result words missing", 0, bus_exp_q.size());
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
